@@ src/bond_pkg.sv @@
`default_nettype none

package bond_pkg;

  // Sequence store geometry, fixed by the 12-bit load position.
  localparam int MAX_LEN = 4096;
  localparam int POS_W   = 12;
  localparam int BASE_W  = 8;
  localparam int LEN_W   = 13;

  // Input item function codes.
  localparam logic [1:0] FUNC_LOAD_Q = 2'd0;
  localparam logic [1:0] FUNC_LOAD_T = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // Configuration register indexes and widths.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_TOL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TENTHS = 2'd1;
  localparam int TOL_W    = 10;
  localparam int TENTHS_W = 4;
  localparam logic [TOL_W-1:0]    TOL_RESET    = 10'd16;
  localparam logic [TENTHS_W-1:0] TENTHS_RESET = 4'd3;

  // Result field widths.
  localparam int DIST_W   = 12;
  localparam int COORD_W  = 13;
  localparam int ALNLEN_W = 13;

  // Edit limit: tenths times summed lengths, then divided by ten through a
  // reciprocal multiply (exact for every product below 2**18).
  localparam int SUM_W       = 14;
  localparam int PROD_W      = 17;
  localparam int RECIP_W     = 16;
  localparam int SCL_W       = PROD_W + RECIP_W;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_TENTH = 16'd52429;

endpackage

`default_nettype wire

@@ src/bond_ram.sv @@
`default_nettype none

module bond_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/bond_lim.sv @@
`default_nettype none

module bond_lim
  import bond_pkg::*;
#(
  parameter int MAX_DIFF = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [TENTHS_W-1:0]           tenths,
  input  wire logic [SUM_W-1:0]              len_sum,
  output logic                               vld,
  output logic [$clog2(MAX_DIFF+1)-1:0]      lim
);

  localparam int DBW = $clog2(MAX_DIFF+1);

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic              stage_r, stage_nxt;
  logic              vld_r, vld_nxt;
  logic [SCL_W-1:0]  scaled;

  // Two steps: the tenths product, then the divide by ten as a multiply by
  // the scaled reciprocal and a shift.
  always_comb begin
    scaled    = SCL_W'(prod_r) * SCL_W'(RECIP_TENTH);
    prod_nxt  = prod_r;
    quo_nxt   = quo_r;
    stage_nxt = 1'b0;
    vld_nxt   = vld_r;
    if (start) begin
      prod_nxt  = PROD_W'(tenths) * PROD_W'(len_sum);
      stage_nxt = 1'b1;
      vld_nxt   = 1'b0;
    end else if (stage_r) begin
      quo_nxt = PROD_W'(scaled >> RECIP_SHIFT);
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      vld_r   <= vld_nxt;
    end
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
  end

  // Saturate the quotient at the edit ceiling.
  assign vld = vld_r;
  assign lim = (quo_r > PROD_W'(MAX_DIFF)) ? DBW'(MAX_DIFF) : DBW'(quo_r);

endmodule

`default_nettype wire

@@ src/banded_ond_sequence_alignment.sv @@
`default_nettype none

// Banded greedy O(ND) alignment engine. Load words (query or target base) are
// taken one per cycle while busy is low and never raise busy. A start word
// raises busy until its single result word is strobed on out_valid for one
// cycle; the receiver cannot stall it, so capture it when it appears. A start
// costs a clear sweep of the diagonal store, with the edit limit computed
// alongside, then for each edit count: a check of the limit and the band
// width, for each diagonal in the band a read of both neighbour diagonals, a
// pick of the start point, extension along matched bases, with a compare per
// base, and a write of the reach, and then a pass over the band to prune it.
// The result word appears in the cycle after the last step, as busy drops.
// All work runs through one sequencer over simple dual-port memories, with at
// most one read and one write per cycle on each store.
module banded_ond_sequence_alignment
  import bond_pkg::*;
#(
  parameter int MAX_DIFF = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_func,
  input  wire logic [POS_W-1:0]     in_position,
  input  wire logic [BASE_W-1:0]    in_base,
  input  wire logic [LEN_W-1:0]     in_query_len,
  input  wire logic [LEN_W-1:0]     in_target_len,
  output logic                      out_valid,
  output logic                      out_aligned,
  output logic [DIST_W-1:0]         out_distance,
  output logic [COORD_W-1:0]        out_query_end,
  output logic [COORD_W-1:0]        out_target_end,
  output logic [ALNLEN_W-1:0]       out_aligned_length,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int DIAG_DEPTH = 2*MAX_DIFF + 1;
  localparam int DIW = $clog2(DIAG_DEPTH);
  localparam int DBW = $clog2(MAX_DIFF+1);
  localparam int XW  = $clog2(MAX_LEN+2);
  localparam int SW  = $clog2(2*MAX_LEN + 2*MAX_DIFF + 4) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_DTOP, S_RDM, S_RDP, S_PICK, S_EXT, S_CMP, S_WR, S_PRD, S_PCMP
  } state_t;

  state_t state_r, state_nxt;

  logic [TOL_W-1:0]    tol_r;
  logic [TENTHS_W-1:0] tenths_r;

  logic [LEN_W-1:0] qlen_r, qlen_nxt, tlen_r, tlen_nxt;
  logic [DIW-1:0]   clr_r, clr_nxt;
  logic             clr_done_r, clr_done_nxt;
  logic [DBW-1:0]   d_r, d_nxt;
  logic signed [SW-1:0] k_r, k_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [SW-1:0] x_r, x_nxt, y_r, y_nxt, xm_r, xm_nxt;
  logic signed [SW-1:0] best_r, best_nxt, plo_r, plo_nxt, phi_r, phi_nxt;

  logic                 ov_r, ov_nxt, oal_r, oal_nxt;
  logic [DIST_W-1:0]    odist_r, odist_nxt;
  logic [COORD_W-1:0]   oqe_r, oqe_nxt, ote_r, ote_nxt;
  logic [ALNLEN_W-1:0]  olen_r, olen_nxt;

  logic accept;
  logic [LEN_W-1:0] qsat, tsat;
  logic lim_start, lim_vld;
  logic [DBW-1:0] max_d;

  logic             fx_we, rs_we;
  logic [DIW-1:0]   fx_waddr, fx_raddr, k_addr;
  logic [XW-1:0]    fx_wdata, fx_rdata;
  logic [SW-1:0]    rs_rdata;
  logic [BASE_W-1:0] q_rdata, t_rdata;

  logic signed [SW-1:0] kofs, kmofs, kpofs, xp, xmr, rs_s, qlen_s, tlen_s, tol_s, d_s;
  logic signed [SW-1:0] xsum, fullsum, knext, pick_x;
  logic                 ext_ok, qual, last_k, is_end;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TOL_RESET;
      tenths_r <= TENTHS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BAND_TOL:   tol_r    <= cfg_data;
        CFG_MAX_TENTHS: tenths_r <= TENTHS_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Lengths saturate at the store depth.
  assign qsat = (in_query_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_query_len;
  assign tsat = (in_target_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_target_len;
  assign lim_start = accept && (in_func == FUNC_START);

  bond_lim #(.MAX_DIFF(MAX_DIFF)) u_lim (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lim_start),
    .tenths  (tenths_r),
    .len_sum (SUM_W'(qsat) + SUM_W'(tsat)),
    .vld     (lim_vld),
    .lim     (max_d)
  );

  // Sequence stores.
  bond_ram #(.WIDTH(BASE_W), .DEPTH(MAX_LEN)) u_qram (
    .clk   (clk),
    .we    (accept && (in_func == FUNC_LOAD_Q)),
    .waddr (in_position),
    .wdata (in_base),
    .raddr (POS_W'(x_r)),
    .rdata (q_rdata)
  );

  bond_ram #(.WIDTH(BASE_W), .DEPTH(MAX_LEN)) u_tram (
    .clk   (clk),
    .we    (accept && (in_func == FUNC_LOAD_T)),
    .waddr (in_position),
    .wdata (in_base),
    .raddr (POS_W'(y_r)),
    .rdata (t_rdata)
  );

  // Diagonal stores: furthest x and reach per diagonal.
  assign kofs  = k_r + SW'(MAX_DIFF);
  assign kmofs = kofs - SW'(1);
  assign kpofs = kofs + SW'(1);
  assign k_addr = kofs[DIW-1:0];

  assign fx_we    = (state_r == S_CLEAR && !clr_done_r) || (state_r == S_WR);
  assign fx_waddr = (state_r == S_CLEAR) ? clr_r : k_addr;
  assign fx_wdata = (state_r == S_CLEAR) ? '0 : XW'(x_r);
  assign fx_raddr = (state_r == S_RDM) ? kmofs[DIW-1:0] : kpofs[DIW-1:0];
  assign rs_we    = (state_r == S_WR);

  bond_ram #(.WIDTH(XW), .DEPTH(DIAG_DEPTH)) u_fxram (
    .clk   (clk),
    .we    (fx_we),
    .waddr (fx_waddr),
    .wdata (fx_wdata),
    .raddr (fx_raddr),
    .rdata (fx_rdata)
  );

  bond_ram #(.WIDTH(SW), .DEPTH(DIAG_DEPTH)) u_rsram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (k_addr),
    .wdata (xsum),
    .raddr (k_addr),
    .rdata (rs_rdata)
  );

  // Shared datapath terms.
  assign xp      = $signed(SW'(fx_rdata));
  assign xmr     = $signed(SW'(fx_rdata));
  assign rs_s    = $signed(rs_rdata);
  assign qlen_s  = $signed(SW'(qlen_r));
  assign tlen_s  = $signed(SW'(tlen_r));
  assign tol_s   = $signed(SW'(tol_r));
  assign d_s     = $signed(SW'(d_r));
  assign xsum    = x_r + y_r;
  assign fullsum = xsum + d_s;
  assign knext   = k_r + SW'(2);
  assign last_k  = (knext > hi_r);
  assign ext_ok  = (x_r < qlen_s) && (y_r >= 0) && (y_r < tlen_s);
  assign is_end  = (x_r >= qlen_s) || (y_r >= tlen_s);
  assign qual    = (rs_s >= best_r - tol_s);
  assign pick_x  = ((k_r == lo_r) || ((k_r != hi_r) && (xm_r < xp))) ? xp : (xm_r + SW'(1));

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    qlen_nxt = qlen_r;  tlen_nxt = tlen_r;
    clr_nxt = clr_r;    clr_done_nxt = clr_done_r;
    d_nxt = d_r;        k_nxt = k_r;
    lo_nxt = lo_r;      hi_nxt = hi_r;
    x_nxt = x_r;        y_nxt = y_r;      xm_nxt = xm_r;
    best_nxt = best_r;  plo_nxt = plo_r;  phi_nxt = phi_r;
    ov_nxt = 1'b0;      oal_nxt = oal_r;
    odist_nxt = odist_r; oqe_nxt = oqe_r; ote_nxt = ote_r; olen_nxt = olen_r;
    unique case (state_r)
      S_IDLE: begin
        if (lim_start) begin
          qlen_nxt = qsat;
          tlen_nxt = tsat;
          clr_nxt = '0;
          clr_done_nxt = 1'b0;
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (!clr_done_r) begin
          clr_nxt = clr_r + 1'b1;
          if (clr_r == DIW'(DIAG_DEPTH-1)) clr_done_nxt = 1'b1;
        end
        if (clr_done_r && lim_vld) begin
          best_nxt = -SW'(1);
          lo_nxt = '0;
          hi_nxt = '0;
          d_nxt = '0;
          state_nxt = S_DTOP;
        end
      end
      S_DTOP: begin
        if ((d_r >= max_d) || ((hi_r - lo_r) > (tol_s <<< 1))) begin
          ov_nxt = 1'b1;
          oal_nxt = 1'b0;
          odist_nxt = '0; oqe_nxt = '0; ote_nxt = '0; olen_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = lo_r;
          state_nxt = S_RDM;
        end
      end
      S_RDM: state_nxt = S_RDP;
      S_RDP: begin
        xm_nxt = xmr;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        x_nxt = pick_x;
        y_nxt = pick_x - k_r;
        state_nxt = S_EXT;
      end
      S_EXT: state_nxt = ext_ok ? S_CMP : S_WR;
      S_CMP: begin
        if (q_rdata == t_rdata) begin
          x_nxt = x_r + SW'(1);
          y_nxt = y_r + SW'(1);
          state_nxt = S_EXT;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        if (xsum > best_r) best_nxt = xsum;
        if (is_end) begin
          ov_nxt = 1'b1;
          oal_nxt = 1'b1;
          odist_nxt = DIST_W'(d_r);
          oqe_nxt = COORD_W'(x_r);
          ote_nxt = (y_r < 0) ? '0 : COORD_W'(y_r);
          olen_nxt = (fullsum < 0) ? '0 : ALNLEN_W'(fullsum >>> 1);
          state_nxt = S_IDLE;
        end else if (last_k) begin
          plo_nxt = hi_r;
          phi_nxt = lo_r;
          k_nxt = lo_r;
          state_nxt = S_PRD;
        end else begin
          k_nxt = knext;
          state_nxt = S_RDM;
        end
      end
      S_PRD: state_nxt = S_PCMP;
      S_PCMP: begin
        if (qual && (k_r < plo_r)) plo_nxt = k_r;
        if (qual && (k_r > phi_r)) phi_nxt = k_r;
        if (last_k) begin
          lo_nxt = ((qual && (k_r < plo_r)) ? k_r : plo_r) - SW'(1);
          hi_nxt = ((qual && (k_r > phi_r)) ? k_r : phi_r) + SW'(1);
          d_nxt = d_r + 1'b1;
          state_nxt = S_DTOP;
        end else begin
          k_nxt = knext;
          state_nxt = S_PRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      clr_done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      clr_done_r <= clr_done_nxt;
    end
    qlen_r <= qlen_nxt;  tlen_r <= tlen_nxt;
    clr_r <= clr_nxt;    d_r <= d_nxt;
    k_r <= k_nxt;        lo_r <= lo_nxt;    hi_r <= hi_nxt;
    x_r <= x_nxt;        y_r <= y_nxt;      xm_r <= xm_nxt;
    best_r <= best_nxt;  plo_r <= plo_nxt;  phi_r <= phi_nxt;
    oal_r <= oal_nxt;    odist_r <= odist_nxt;
    oqe_r <= oqe_nxt;    ote_r <= ote_nxt;  olen_r <= olen_nxt;
  end

  assign out_valid          = ov_r;
  assign out_aligned        = oal_r;
  assign out_distance       = odist_r;
  assign out_query_end      = oqe_r;
  assign out_target_end     = ote_r;
  assign out_aligned_length = olen_r;

  // A result word only follows a running walk.
  a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r != S_IDLE))
    else $error("result word without a walk");

  // An unaligned result carries only zeros.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_aligned) |-> (out_distance == '0 && out_query_end == '0 &&
      out_target_end == '0 && out_aligned_length == '0))
    else $error("unaligned result is not zero");

  // Extension only runs on a diagonal inside the band.
  a_k_in_band: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXT) |-> (k_r >= lo_r && k_r <= hi_r && x_r >= 0))
    else $error("diagonal outside the band");

  // Load words never make the block busy.
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func != FUNC_START) |=> !busy)
    else $error("load word raised busy");

endmodule

`default_nettype wire
